### rtl/sct_pkg.sv
// package: constants, quarter-wave table and shared types for the sine/cosine block
package sct_pkg;

  localparam logic CmdSine   = 1'b0;
  localparam logic CmdCosine = 1'b1;

  localparam int unsigned AngleW  = 24;
  localparam int unsigned ResultW = 17;
  localparam int unsigned RomW    = 16;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned FracW   = 8;
  localparam int unsigned WholeW  = 16;
  localparam int unsigned DiffW   = 11;

  localparam logic [AngleW:0]   CosOffset   = 25'd69120;
  localparam logic [WholeW-1:0] RecipMul    = 16'd46604;
  localparam logic [WholeW-1:0] FullTurn    = 16'd360;
  localparam logic [8:0]        HalfTurn    = 9'd180;
  localparam logic [7:0]        QuarterTurn = 8'd90;
  localparam logic [7:0]        MirrorBase  = 8'd180;
  localparam logic [7:0]        MirrorFrac  = 8'd179;
  localparam logic [FracW-1:0]  FracMax     = 8'd255;
  localparam logic [IdxW-1:0]   LastIdx     = 7'd90;

  localparam logic [RomW-1:0] QuarterRom [91] = '{
    16'd0,
    16'd1145,  16'd2289,  16'd3435,  16'd4572,  16'd5716,  16'd6853,  16'd7989,  16'd9125,
    16'd10255, 16'd11385, 16'd12508, 16'd13631, 16'd14745, 16'd15859, 16'd16963, 16'd18067,
    16'd19165, 16'd20253, 16'd21342, 16'd22417, 16'd23489, 16'd24553, 16'd25610, 16'd26659,
    16'd27703, 16'd28731, 16'd29755, 16'd30773, 16'd31777, 16'd32772, 16'd33756, 16'd34734,
    16'd35697, 16'd36649, 16'd37594, 16'd38523, 16'd39445, 16'd40350, 16'd41247, 16'd42131,
    16'd42998, 16'd43856, 16'd44701, 16'd45528, 16'd46344, 16'd47147, 16'd47931, 16'd48708,
    16'd49461, 16'd50205, 16'd50933, 16'd51646, 16'd52342, 16'd53022, 16'd53686, 16'd54334,
    16'd54969, 16'd55579, 16'd56180, 16'd56760, 16'd57322, 16'd57866, 16'd58394, 16'd58908,
    16'd59399, 16'd59871, 16'd60327, 16'd60768, 16'd61184, 16'd61584, 16'd61969, 16'd62330,
    16'd62677, 16'd63000, 16'd63304, 16'd63593, 16'd63858, 16'd64108, 16'd64334, 16'd64545,
    16'd64731, 16'd64903, 16'd65049, 16'd65177, 16'd65289, 16'd65377, 16'd65449, 16'd65501,
    16'd65527, 16'd65535
  };

  typedef struct packed {
    logic [IdxW-1:0]  y;
    logic [FracW-1:0] frac;
    logic             neg;
  } sct_fold_t;

  function automatic logic [RomW-1:0] rom_read(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] i;
    i = (idx > LastIdx) ? LastIdx : idx;
    return QuarterRom[i];
  endfunction

endpackage

### rtl/sine_cosine_table_interpolate.sv
// top level: sine/cosine by quarter-wave table lookup with linear interpolation
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid_i, in_ready_o, cmd_i,   | in
//           | angle_i                          |
//   result  | out_valid_o, out_ready_i,        | out
//           | result_o                         |
//
// four register stages: input, quotient, table read, result
// one transaction per cycle unless the result stalls; the result is valid once it has passed the later stages
// the quotient multiply and the interpolation multiply set the stage split
// reset clears only the stage valid bits; no clearing pass
// a stalled result freezes every stage and drops in_ready_o
module sine_cosine_table_interpolate (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [sct_pkg::AngleW-1:0]         angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sct_pkg::ResultW-1:0]        result_o
);
  import sct_pkg::*;

  logic              en;
  logic [3:0]        valid_q;
  logic [3:0]        valid_d;
  sct_fold_t         fold;

  assign en      = ~valid_q[3] | out_ready_i;
  assign valid_d = {valid_q[2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  sct_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cmd_i   (cmd_i),
    .angle_i (angle_i),
    .fold_o  (fold)
  );

  sct_interp u_interp (
    .clk_i    (clk_i),
    .en_i     (en),
    .fold_i   (fold),
    .result_o (result_o)
  );

  assign in_ready_o  = en;
  assign out_valid_o = valid_q[3];

endmodule

### rtl/sct_reduce.sv
// angle reduction: offset, magnitude, whole degrees mod 360, half-turn fold and mirror
module sct_reduce (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 cmd_i,
  input  logic [sct_pkg::AngleW-1:0]           angle_i,
  output sct_pkg::sct_fold_t                   fold_o
);
  import sct_pkg::*;

  logic                 cmd_q;
  logic [AngleW-1:0]    angle_q;
  logic [AngleW:0]      ofs;
  logic [AngleW:0]      a;
  logic [AngleW:0]      mag;
  logic                 neg_d;
  logic [WholeW-1:0]    whole_d;
  logic [FracW-1:0]     frac_d;
  logic [31:0]          prod;
  logic [IdxW-1:0]      quot_d;

  logic [WholeW-1:0]    whole_q;
  logic [IdxW-1:0]      quot_q;
  logic [FracW-1:0]     frac_q;
  logic                 neg_q;

  logic [WholeW-1:0]    base;
  logic [WholeW-1:0]    rem;
  logic [8:0]           y9;
  logic [7:0]           y8;
  logic [FracW-1:0]     frac_f;
  logic                 neg_f;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q   <= cmd_i;
      angle_q <= angle_i;
    end
  end

  always_comb begin
    ofs     = (cmd_q == CmdCosine) ? CosOffset : '0;
    a       = {angle_q[AngleW-1], angle_q} - ofs;
    neg_d   = a[AngleW];
    mag     = neg_d ? (~a + 25'd1) : a;
    whole_d = mag[AngleW-1:FracW];
    frac_d  = mag[FracW-1:0];
    prod    = {16'd0, whole_d} * {16'd0, RecipMul};
    quot_d  = prod[30:24];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      whole_q <= whole_d;
      quot_q  <= quot_d;
      frac_q  <= frac_d;
      neg_q   <= neg_d;
    end
  end

  always_comb begin
    base   = {9'd0, quot_q} * FullTurn;
    rem    = whole_q - base;
    y9     = rem[8:0];
    neg_f  = neg_q;
    frac_f = frac_q;
    if (y9 >= HalfTurn) begin
      y9    = y9 - HalfTurn;
      neg_f = ~neg_q;
    end
    y8 = y9[7:0];
    if (y8 >= QuarterTurn) begin
      if (frac_q != '0) begin
        y8     = MirrorFrac - y8;
        frac_f = FracMax - frac_q;
      end else begin
        y8 = MirrorBase - y8;
      end
    end
    fold_o.y    = y8[IdxW-1:0];
    fold_o.frac = frac_f;
    fold_o.neg  = neg_f;
  end

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

### rtl/sct_interp.sv
// table read, linear interpolation and sign application
module sct_interp (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  sct_pkg::sct_fold_t            fold_i,
  output logic [sct_pkg::ResultW-1:0]   result_o
);
  import sct_pkg::*;

  logic [RomW-1:0]    rom_lo;
  logic [RomW-1:0]    rom_hi;
  logic [RomW-1:0]    diff;

  logic [RomW-1:0]    v0_q;
  logic [DiffW-1:0]   diff_q;
  logic [FracW-1:0]   frac_q;
  logic               neg_q;

  logic [15:0]        step;
  logic [RomW-1:0]    v;
  logic [ResultW-1:0] result_d;
  logic [ResultW-1:0] result_q;

  always_comb begin
    rom_lo = rom_read(fold_i.y);
    rom_hi = rom_read(fold_i.y + 7'd1);
    diff   = rom_hi - rom_lo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v0_q   <= rom_lo;
      diff_q <= diff[DiffW-1:0];
      frac_q <= fold_i.frac;
      neg_q  <= fold_i.neg;
    end
  end

  always_comb begin
    step = {8'd0, diff_q[DiffW-1:3]} * {8'd0, frac_q};
    v    = v0_q + {5'd0, step[15:5]};
    if (neg_q && (v != '0)) begin
      result_d = ~{1'b0, v} + 17'd1;
    end else begin
      result_d = {1'b0, v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

### rtl/sct_checker.sv
// port-level checker for the sine/cosine block and its bind
module sct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               cmd_i,
  input logic [sct_pkg::AngleW-1:0]         angle_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [sct_pkg::ResultW-1:0]        result_o
);
  import sct_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ cmd_i ^ (^angle_i);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed while stalled");

  // magnitude never exceeds full scale
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_o != 17'h10000)
    else $error("result out of range");

  // no pending result means the pipeline can take a transaction
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind sine_cosine_table_interpolate sct_checker u_sct_checker (.*);

### verif/sine_cosine_table_interpolate_tb.sv
// testbench: random and directed angles for the sine/cosine table block, checked per transaction
`timescale 1ns / 100ps

module sine_cosine_table_interpolate_tb;
  import sct_pkg::*;

  typedef struct {
    logic              cmd;
    logic [AngleW-1:0] angle;
    bit                hold;
  } angle_item_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               cmd_i;
  logic [AngleW-1:0]  angle_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ResultW-1:0] result_o;

  angle_item_t        angle_q[$];
  logic [ResultW-1:0] value_q[$];
  logic [ResultW-1:0] want_value;
  int unsigned        acc_cnt;
  int unsigned        rx_cnt;
  int unsigned        acc_now;
  int unsigned        err_cnt;
  bit                 in_idle;

  sine_cosine_table_interpolate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [ResultW-1:0] sincos_value(logic cmd, logic [AngleW-1:0] angle);
    int                 a;
    bit                 neg;
    int unsigned        mag;
    int unsigned        frac;
    int unsigned        deg;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        v;
    logic [ResultW-1:0] r;
    a = int'($signed(angle)) - ((cmd == CmdCosine) ? int'(CosOffset) : 0);
    neg = (a < 0);
    mag = neg ? -a : a;
    frac = mag & 255;
    deg = (mag >> 8) % 360;
    if (deg >= 180) begin
      deg = deg - 180;
      neg = !neg;
    end
    if (deg >= 90) begin
      deg = 180 - deg;
      if (frac != 0) begin
        frac = 255 - frac;
        deg = deg - 1;
      end
    end
    lo = QuarterRom[deg];
    v = lo;
    if (frac != 0) begin
      hi = QuarterRom[deg + 1];
      v = lo + (((hi - lo) / 8) * frac) / 32;
    end
    if (v > 65535) v = 65535;
    r = v[ResultW-1:0];
    if (neg && v != 0) r = -r;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ResultW-1:0] got,
                                 logic [ResultW-1:0] want);
    $display("%0t ns: %s: result got %0d want %0d", $time, what,
             $signed(got), $signed(want));
    err_cnt++;
  endtask

  task automatic add_angle(logic cmd, int angle, bit hold);
    angle_item_t it;
    it.cmd = cmd;
    it.angle = angle[AngleW-1:0];
    it.hold = hold;
    angle_q.push_back(it);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= CmdSine;
      angle_i <= '0;
      acc_cnt <= 0;
    end else begin
      acc_now = acc_cnt + ((in_valid_i && in_ready_o) ? 1 : 0);
      acc_cnt <= acc_now;
      if (!in_valid_i || in_ready_o) begin
        in_idle = (acc_cnt >= 500 && acc_cnt < 800) ? 1'b0 : ($urandom_range(99) < 36);
        if (angle_q.size() != 0 && !in_idle && !(angle_q[0].hold && acc_now != rx_cnt)) begin
          in_valid_i <= 1'b1;
          cmd_i <= angle_q[0].cmd;
          angle_i <= angle_q[0].angle;
          void'(angle_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cnt <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rx_cnt <= rx_cnt + 1;
        if (value_q.size() == 0) begin
          report_mismatch("transaction with nothing pending", result_o, 'x);
        end else begin
          want_value = value_q.pop_front();
          if (result_o !== want_value) report_mismatch("wrong value", result_o, want_value);
        end
      end
      if (in_valid_i && in_ready_o) value_q.push_back(sincos_value(cmd_i, angle_i));
      out_ready_i <= (rx_cnt >= 500 && rx_cnt < 800) ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  initial begin
    int unsigned pick;
    int          whole;
    int          fr;
    int          ang;
    int          edge_deg[12];
    edge_deg = '{0, 89, 90, 91, 179, 180, 181, 269, 270, 271, 359, 360};
    err_cnt = 0;
    rst_ni = 1'b0;

    add_angle(CmdSine, 0, 1'b0);
    add_angle(CmdSine, 8388607, 1'b0);
    add_angle(CmdSine, -8388608, 1'b0);
    add_angle(CmdSine, 1, 1'b0);
    add_angle(CmdSine, -1, 1'b0);
    add_angle(CmdSine, 255, 1'b0);
    add_angle(CmdSine, -255, 1'b0);
    add_angle(CmdSine, 90 * 256, 1'b0);
    add_angle(CmdSine, 90 * 256 + 1, 1'b0);
    add_angle(CmdSine, 90 * 256 + 255, 1'b0);
    add_angle(CmdSine, 135 * 256 + 255, 1'b0);
    add_angle(CmdSine, 180 * 256, 1'b0);
    add_angle(CmdSine, -180 * 256, 1'b0);
    add_angle(CmdSine, 270 * 256, 1'b0);
    add_angle(CmdSine, 359 * 256 + 255, 1'b0);
    add_angle(CmdSine, 360 * 256, 1'b0);
    add_angle(CmdSine, -360 * 256, 1'b0);
    add_angle(CmdSine, -90 * 256, 1'b0);
    add_angle(CmdCosine, 0, 1'b0);
    add_angle(CmdCosine, 270 * 256, 1'b0);
    add_angle(CmdCosine, 90 * 256, 1'b0);
    add_angle(CmdCosine, -8388608, 1'b0);
    add_angle(CmdCosine, 8388607, 1'b0);
    add_angle(CmdCosine, 180 * 256 + 128, 1'b0);

    for (int i = 0; i < 1250; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        ang = int'($signed($urandom_range(32'hFFFFFF) << 8)) >>> 8;
      end else if (pick < 75) begin
        ang = int'($urandom_range(368640)) - 184320;
      end else begin
        whole = edge_deg[$urandom_range(11)];
        case ($urandom_range(3))
          0: fr = 0;
          1: fr = 1;
          2: fr = 255;
          default: fr = $urandom_range(255);
        endcase
        ang = whole * 256 + fr;
        if ($urandom_range(1)) ang = -ang;
      end
      add_angle($urandom_range(1) ? CmdCosine : CmdSine, ang, (i == 300 || i == 900));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (angle_q.size() == 0 && !in_valid_i);
    wait (value_q.size() == 0 && rx_cnt == acc_cnt);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sine_cosine_table_interpolate_tb: clean");
    end else begin
      $display("sine_cosine_table_interpolate_tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("sine_cosine_table_interpolate_tb: errors");
    $finish;
  end

endmodule

### filelist.f
rtl/sct_pkg.sv
rtl/sct_reduce.sv
rtl/sct_interp.sv
rtl/sine_cosine_table_interpolate.sv
rtl/sct_checker.sv
verif/sine_cosine_table_interpolate_tb.sv
